FILE: design/pip_pkg.sv
`default_nettype none
package pip_pkg;

  localparam int COORD_BITS = 16;
  localparam int RAY_BITS = 15;
  localparam int COUNT_BITS = 16;

  // ray end x and the differences built from it
  localparam int RX_BITS = ((COORD_BITS > RAY_BITS) ? COORD_BITS : RAY_BITS) + 2;
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int RDIFF_BITS = RX_BITS + 1;
  localparam int PROD_BITS = DIFF_BITS + RDIFF_BITS;
  localparam int ORIENT_BITS = PROD_BITS + 1;

  localparam logic [RAY_BITS-1:0] RAY_RESET = RAY_BITS'(1000);

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;
  localparam logic REG_RAY_LENGTH = 1'b0;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t vertex_x;
    coord_t vertex_y;
    logic   first_vertex;
    logic   last_vertex;
  } pip_in_t;

  typedef struct packed {
    logic                  inside_res;
    logic [COUNT_BITS-1:0] crossing_count;
  } pip_out_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } pip_edge_t;

  typedef struct packed {
    pip_edge_t edge0;
    pip_edge_t edge1;
    coord_t    px;
    coord_t    py;
    logic      use0;
    logic      use1;
    logic      first;
    logic      last;
  } pip_job_t;

endpackage
`default_nettype wire

FILE: design/point_in_polygon_test_top.sv
`default_nettype none
// crossing-number point-in-polygon test. unless stalled, vertices arrive one word per
// cycle with the query point on the word that has first_vertex set; the word with
// last_vertex set also closes the polygon and yields one result word (parity and
// saturating crossing count). a front stage tracks query point, first and previous
// vertex and forms edges from the previous vertex and, on the last word, to the first;
// a 4-entry queue feeds a back pipeline that tests both edges in parallel over three
// stages (differences, three products, signs) and then accumulates. sustained rate is one
// vertex word per cycle while the output is not stalled. ray_length (offset 0) is written
// over the apb port; the user must write it only while idle, the block itself does not enforce this.
module point_in_polygon_test_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire pip_pkg::pip_in_t                   in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output pip_pkg::pip_out_t                       out_data_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [pip_pkg::PADDR_BITS-1:0]     paddr,
  input  wire logic [pip_pkg::PDATA_BITS-1:0]     pwdata,
  output logic [pip_pkg::PDATA_BITS-1:0]          prdata,
  output logic                                    pready
);
  import pip_pkg::*;

  logic [RAY_BITS-1:0] ray_len_q;
  logic                q_full, q_push, q_valid, q_pop, reg_hit;
  pip_job_t            push_job, head_job;

  assign pready  = 1'b1;
  assign reg_hit = paddr[PADDR_BITS-1] == REG_RAY_LENGTH;
  assign prdata  = reg_hit ? {{(PDATA_BITS-RAY_BITS){1'b0}}, ray_len_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ray_len_q <= RAY_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      ray_len_q <= pwdata[RAY_BITS-1:0];
    end
  end

  pip_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (q_full),
    .push_o     (q_push),
    .job_o      (push_job)
  );

  pip_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (head_job)
  );

  pip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_pop_o   (q_pop),
    .job_i       (head_job),
    .ray_len_i   (ray_len_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

FILE: design/pip_front.sv
`default_nettype none
module pip_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire pip_pkg::pip_in_t  in_data_i,
  input  wire logic              full_i,
  output logic                   push_o,
  output pip_pkg::pip_job_t      job_o
);
  import pip_pkg::*;

  coord_t query_x_q, query_y_q, first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic   accept;

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;
  assign push_o     = accept;

  always_comb begin
    job_o.edge0.ax = prev_x_q;
    job_o.edge0.ay = prev_y_q;
    job_o.edge0.bx = in_data_i.vertex_x;
    job_o.edge0.by = in_data_i.vertex_y;
    job_o.edge1.ax = in_data_i.vertex_x;
    job_o.edge1.ay = in_data_i.vertex_y;
    job_o.edge1.bx = in_data_i.first_vertex ? in_data_i.vertex_x : first_x_q;
    job_o.edge1.by = in_data_i.first_vertex ? in_data_i.vertex_y : first_y_q;
    job_o.px       = in_data_i.first_vertex ? in_data_i.point_x : query_x_q;
    job_o.py       = in_data_i.first_vertex ? in_data_i.point_y : query_y_q;
    job_o.use0     = !in_data_i.first_vertex;
    job_o.use1     = in_data_i.last_vertex;
    job_o.first    = in_data_i.first_vertex;
    job_o.last     = in_data_i.last_vertex;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_x_q <= '0;
      query_y_q <= '0;
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
    end else if (accept) begin
      if (in_data_i.first_vertex) begin
        query_x_q <= in_data_i.point_x;
        query_y_q <= in_data_i.point_y;
        first_x_q <= in_data_i.vertex_x;
        first_y_q <= in_data_i.vertex_y;
      end
      prev_x_q <= in_data_i.vertex_x;
      prev_y_q <= in_data_i.vertex_y;
    end
  end

endmodule
`default_nettype wire

FILE: design/pip_queue.sv
`default_nettype none
module pip_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire pip_pkg::pip_job_t push_data_i,
  output logic                   full_o,
  output logic                   pop_valid_o,
  input  wire logic              pop_i,
  output pip_pkg::pip_job_t      pop_data_o
);
  import pip_pkg::*;

  pip_job_t             mem_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wptr_q, rptr_q;
  logic [QCNT_BITS-1:0] count_q;
  logic                 do_push, do_pop;

  assign full_o      = count_q == QCNT_BITS'(QUEUE_DEPTH);
  assign pop_valid_o = count_q != '0;
  assign pop_data_o  = mem_q[rptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
    return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= next_ptr(wptr_q);
      end
      if (do_pop) begin
        rptr_q <= next_ptr(rptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCNT_BITS'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue count above depth");
`endif

endmodule
`default_nettype wire

FILE: design/pip_edge.sv
`default_nettype none
module pip_edge (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire pip_pkg::pip_edge_t            edge_i,
  input  wire pip_pkg::coord_t               px_i,
  input  wire pip_pkg::coord_t               py_i,
  input  wire logic [pip_pkg::RAY_BITS-1:0]  ray_len_i,
  output logic                               hit_o
);
  import pip_pkg::*;

  coord_t                         ax, ay, bx, by, px, py;
  logic signed [RX_BITS-1:0]      rx;
  logic signed [DIFF_BITS-1:0]    dyab_d, dxpb_d, dxab_d, dypb_d;
  logic signed [RDIFF_BITS-1:0]   dxrb_d;
  logic [1:0]                     o1_d, o2_d;
  logic                           lz, s12_d, bnd3_d, bnd4_d;

  logic signed [DIFF_BITS-1:0]    dyab_q, dxpb_q, dxab_q, dypb_q;
  logic signed [RDIFF_BITS-1:0]   dxrb_q;
  logic [1:0]                     o1_q, o2_q, o1_qq, o2_qq;
  logic                           s12_q, bnd3_q, bnd4_q, s12_qq, bnd3_qq, bnd4_qq;

  logic signed [PROD_BITS-1:0]    m1_q, m2_q, m3_q;
  logic signed [ORIENT_BITS-1:0]  o3v, o4v;
  logic [1:0]                     o3c, o4c;
  logic                           hit_d, hit_q;

  // stage 1: differences, ray-side orientation signs and bound checks
  always_comb begin
    ax = edge_i.ax;
    ay = edge_i.ay;
    bx = edge_i.bx;
    by = edge_i.by;
    px = px_i;
    py = py_i;
    rx = {{(RX_BITS-COORD_BITS){px[COORD_BITS-1]}}, px}
       + {{(RX_BITS-RAY_BITS){1'b0}}, ray_len_i};
    dyab_d = {by[COORD_BITS-1], by} - {ay[COORD_BITS-1], ay};
    dxpb_d = {px[COORD_BITS-1], px} - {bx[COORD_BITS-1], bx};
    dxab_d = {bx[COORD_BITS-1], bx} - {ax[COORD_BITS-1], ax};
    dypb_d = {py[COORD_BITS-1], py} - {by[COORD_BITS-1], by};
    dxrb_d = {rx[RX_BITS-1], rx} - {{(RDIFF_BITS-COORD_BITS){bx[COORD_BITS-1]}}, bx};
    lz     = ray_len_i == '0;
    // sign codes {negative, positive}; the ray orientation is -len*(y-py)
    o1_d   = {!lz && (ay > py), !lz && (ay < py)};
    o2_d   = {!lz && (by > py), !lz && (by < py)};
    s12_d  = ((ay == py) && (ax >= px) && (ax <= rx))
          || ((by == py) && (bx >= px) && (bx <= rx));
    bnd3_d = ((px >= ax && px <= bx) || (px >= bx && px <= ax))
          && ((py >= ay && py <= by) || (py >= by && py <= ay));
    bnd4_d = ((rx >= ax && rx <= bx) || (rx >= bx && rx <= ax))
          && ((py >= ay && py <= by) || (py >= by && py <= ay));
  end

  // stage 3: edge-side orientation signs and hit decision
  always_comb begin
    o3v   = ORIENT_BITS'(m1_q) - ORIENT_BITS'(m2_q);
    o4v   = ORIENT_BITS'(m3_q) - ORIENT_BITS'(m2_q);
    o3c   = {o3v[ORIENT_BITS-1], !o3v[ORIENT_BITS-1] && (o3v != '0)};
    o4c   = {o4v[ORIENT_BITS-1], !o4v[ORIENT_BITS-1] && (o4v != '0)};
    hit_d = ((o1_qq != o2_qq) && (o3c != o4c))
         || s12_qq
         || ((o3c == 2'b00) && bnd3_qq)
         || ((o4c == 2'b00) && bnd4_qq);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dyab_q  <= dyab_d;
      dxpb_q  <= dxpb_d;
      dxab_q  <= dxab_d;
      dypb_q  <= dypb_d;
      dxrb_q  <= dxrb_d;
      o1_q    <= o1_d;
      o2_q    <= o2_d;
      s12_q   <= s12_d;
      bnd3_q  <= bnd3_d;
      bnd4_q  <= bnd4_d;
      m1_q    <= PROD_BITS'(dyab_q) * PROD_BITS'(dxpb_q);
      m2_q    <= PROD_BITS'(dxab_q) * PROD_BITS'(dypb_q);
      m3_q    <= PROD_BITS'(dyab_q) * PROD_BITS'(dxrb_q);
      o1_qq   <= o1_q;
      o2_qq   <= o2_q;
      s12_qq  <= s12_q;
      bnd3_qq <= bnd3_q;
      bnd4_qq <= bnd4_q;
      hit_q   <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule
`default_nettype wire

FILE: design/pip_back.sv
`default_nettype none
module pip_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          job_valid_i,
  output logic                               job_pop_o,
  input  wire pip_pkg::pip_job_t             job_i,
  input  wire logic [pip_pkg::RAY_BITS-1:0]  ray_len_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output pip_pkg::pip_out_t                  out_data_o
);
  import pip_pkg::*;

  typedef struct packed {
    logic valid;
    logic use0;
    logic use1;
    logic first;
    logic last;
  } ctl_t;

  ctl_t                  ctl_q [3];
  logic                  en, hit0, hit1, h0, h1, retire;
  logic [COUNT_BITS-1:0] base_c, count_d, count_q;
  logic [COUNT_BITS:0]   sum;
  logic                  parity_d, parity_q;
  logic                  out_valid_q;
  pip_out_t              out_data_q;

  assign en        = !out_valid_q || !out_stall_i;
  assign job_pop_o = job_valid_i && en;

  pip_edge u_edge0 (
    .clk_i     (clk_i),
    .en_i      (en),
    .edge_i    (job_i.edge0),
    .px_i      (job_i.px),
    .py_i      (job_i.py),
    .ray_len_i (ray_len_i),
    .hit_o     (hit0)
  );

  pip_edge u_edge1 (
    .clk_i     (clk_i),
    .en_i      (en),
    .edge_i    (job_i.edge1),
    .px_i      (job_i.px),
    .py_i      (job_i.py),
    .ray_len_i (ray_len_i),
    .hit_o     (hit1)
  );

  always_comb begin
    retire   = ctl_q[2].valid && en;
    h0       = ctl_q[2].use0 && hit0;
    h1       = ctl_q[2].use1 && hit1;
    base_c   = ctl_q[2].first ? '0 : count_q;
    sum      = {1'b0, base_c} + (COUNT_BITS + 1)'(h0) + (COUNT_BITS + 1)'(h1);
    count_d  = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
    parity_d = (ctl_q[2].first ? 1'b0 : parity_q) ^ h0 ^ h1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0]    <= '0;
      ctl_q[1]    <= '0;
      ctl_q[2]    <= '0;
      count_q     <= '0;
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      ctl_q[0]    <= '{valid: job_valid_i, use0: job_i.use0, use1: job_i.use1,
                       first: job_i.first, last: job_i.last};
      ctl_q[1]    <= ctl_q[0];
      ctl_q[2]    <= ctl_q[1];
      out_valid_q <= ctl_q[2].valid && ctl_q[2].last;
      if (ctl_q[2].valid) begin
        count_q  <= count_d;
        parity_q <= parity_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (retire && ctl_q[2].last) begin
      out_data_q.inside_res     <= parity_d;
      out_data_q.crossing_count <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_parity_tracks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '1) |-> (parity_q == count_q[0]))
    else $error("parity out of step with unsaturated count");

  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q.crossing_count == count_q)
                 && (out_data_q.inside_res == parity_q))
    else $error("pending result differs from accumulator");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (retire && !ctl_q[2].first) |=> (count_q >= $past(count_q)))
    else $error("crossing count went down within a polygon");

  a_frozen_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(count_q) && $stable(ctl_q[2]))
    else $error("back pipeline moved while result stalled");
`endif

endmodule
`default_nettype wire
